// ===== sv/npt_pkg.sv =====
// npt_pkg: types, codes and sizes for the note pair table.
// Used by npt_cell and note_pair_table_top; depends on nothing.

package npt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   localparam logic [2:0] OP_OPEN   = 3'd0;
   localparam logic [2:0] OP_CLOSE  = 3'd1;
   localparam logic [2:0] OP_ADD    = 3'd2;
   localparam logic [2:0] OP_REMOVE = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;
   localparam logic [2:0] OP_FIX    = 3'd5;
   localparam logic [2:0] OP_READ   = 3'd6;
   localparam logic [2:0] OP_UNUSED = 3'd7;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_BAD_INDEX = 2'd2;
   localparam logic [1:0] ST_NO_MATCH  = 2'd3;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [6:0]         note_number;
      logic signed [31:0] start_position;
      logic signed [31:0] end_position;
      logic               end_present;
      logic [5:0]         entry_index;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [6:0]         entry_count;
      logic [6:0]         read_note;
      logic signed [31:0] read_start;
      logic signed [31:0] read_end;
      logic               read_end_present;
   } rsp_type;

   typedef struct packed {
      logic [6:0]         note;
      logic signed [31:0] start_pos;
      logic signed [31:0] end_pos;
      logic               closed;
   } entry_type;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_WRITE = 3'd1,
      CMD_CLOSE = 3'd2,
      CMD_SHIFT = 3'd3
   } cmd_kind_type;

   // Command broadcast to every cell.
   typedef struct packed {
      cmd_kind_type     kind;
      logic [IDX_W-1:0] idx;
      entry_type        entry;
   } cmd_type;

   // Entry broadcast during the overlap pass.
   typedef struct packed {
      logic               valid;
      logic [6:0]         note;
      logic signed [31:0] start_pos;
   } bcast_type;

endpackage

// ===== sv/note_pair_table_top.sv =====
// note_pair_table_top: controller, read mux and the row of npt_cell slots.
// Depends on npt_pkg and npt_cell.
//
// Usage: one request beat on req_ (valid/ready) gives exactly one response
// beat on rsp_. Open, add, remove, clear, read and unused opcodes finish at
// accept; the response is registered and appears the cycle after accept.
// Close walks the slots from index 0, one slot per cycle, until the first
// open match or the last held slot. The overlap pass broadcasts one slot
// per cycle to every slot, which trims its own end in parallel. The walk
// counter steps over the held slots in both passes.
// One request is in work at a time; req_ready is high only when the
// controller is idle and the response register is free or being taken.
// A stalled receiver holds the response; a walk never waits for it.
// Reset empties the table (held count zero); slot contents are not cleared
// and are written in full before they can be read.

module note_pair_table_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  npt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output npt_pkg::rsp_type rsp_data
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_CLOSE = 4'b0010,
      S_FIX   = 4'b0100,
      S_DRAIN = 4'b1000
   } state_type;

   state_type                  state_ff, state_in;
   logic [npt_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [npt_pkg::IDX_W-1:0]  k_ff, k_in;
   npt_pkg::entry_type         hold_ff, hold_in;
   npt_pkg::bcast_type         bcast_ff, bcast_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   npt_pkg::rsp_type           rsp_ff, rsp_in;

   npt_pkg::cmd_type           cmd;
   npt_pkg::entry_type         cells [npt_pkg::TABLE_DEPTH];
   logic [npt_pkg::TABLE_DEPTH-1:0] hits;
   npt_pkg::entry_type         rd_entry;
   logic [npt_pkg::IDX_W-1:0]  rd_addr;
   logic                       out_free, fire, idx_bad, k_last;
   npt_pkg::entry_type         new_entry;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign fire      = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign idx_bad   = ({1'b0, req_data.entry_index} >= count_ff);
   assign k_last    = ((npt_pkg::CNT_W)'(k_ff) + 1'b1) == count_ff;
   assign rd_addr   = (state_ff == S_FIX) ? k_ff
                      : npt_pkg::IDX_W'(req_data.entry_index);

   always_comb begin
      rd_entry = '0;
      for (int i = 0; i < npt_pkg::TABLE_DEPTH; i++) begin
         if (rd_addr == npt_pkg::IDX_W'(i)) rd_entry = rd_entry | cells[i];
      end
   end

   always_comb begin
      new_entry.note      = req_data.note_number;
      new_entry.start_pos = req_data.start_position;
      new_entry.closed    = (req_data.opcode == npt_pkg::OP_ADD) && req_data.end_present;
      new_entry.end_pos   = new_entry.closed ? req_data.end_position : 32'sd0;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      hold_in      = hold_ff;
      bcast_in     = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      cmd.kind     = npt_pkg::CMD_NONE;
      cmd.idx      = '0;
      cmd.entry    = new_entry;

      case (state_ff)
         S_IDLE: begin
            if (fire) begin
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
               case (req_data.opcode)
                  npt_pkg::OP_OPEN, npt_pkg::OP_ADD: begin
                     if (count_ff == (npt_pkg::CNT_W)'(npt_pkg::TABLE_DEPTH)) begin
                        rsp_in.status = npt_pkg::ST_FULL;
                     end else begin
                        cmd.kind = npt_pkg::CMD_WRITE;
                        cmd.idx  = count_ff[npt_pkg::IDX_W-1:0];
                        count_in = count_ff + 1'b1;
                     end
                  end
                  npt_pkg::OP_CLOSE: begin
                     if (count_ff == '0) begin
                        rsp_in.status = npt_pkg::ST_NO_MATCH;
                     end else begin
                        rsp_valid_in = 1'b0;
                        hold_in      = new_entry;
                        hold_in.end_pos = req_data.end_position;
                        k_in         = '0;
                        state_in     = S_CLOSE;
                     end
                  end
                  npt_pkg::OP_REMOVE: begin
                     if (idx_bad) begin
                        rsp_in.status = npt_pkg::ST_BAD_INDEX;
                     end else begin
                        cmd.kind = npt_pkg::CMD_SHIFT;
                        cmd.idx  = npt_pkg::IDX_W'(req_data.entry_index);
                        count_in = count_ff - 1'b1;
                     end
                  end
                  npt_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  npt_pkg::OP_FIX: begin
                     if (count_ff != '0) begin
                        rsp_valid_in = 1'b0;
                        k_in         = '0;
                        state_in     = S_FIX;
                     end
                  end
                  npt_pkg::OP_READ: begin
                     if (idx_bad) begin
                        rsp_in.status = npt_pkg::ST_BAD_INDEX;
                     end else begin
                        rsp_in.read_note        = rd_entry.note;
                        rsp_in.read_start       = rd_entry.start_pos;
                        rsp_in.read_end         = rd_entry.end_pos;
                        rsp_in.read_end_present = rd_entry.closed;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_in.entry_count = 7'(count_in);
            end
         end
         S_CLOSE: begin
            if (out_free) begin
               cmd.kind  = npt_pkg::CMD_CLOSE;
               cmd.idx   = k_ff;
               cmd.entry = hold_ff;
               if ((|hits) || k_last) begin
                  rsp_in       = '0;
                  rsp_in.status = (|hits) ? npt_pkg::ST_OK : npt_pkg::ST_NO_MATCH;
                  rsp_in.entry_count = 7'(count_ff);
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         S_FIX: begin
            bcast_in.valid     = 1'b1;
            bcast_in.note      = rd_entry.note;
            bcast_in.start_pos = rd_entry.start_pos;
            k_in               = k_ff + 1'b1;
            if (k_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (out_free) begin
               rsp_in             = '0;
               rsp_in.entry_count = 7'(count_ff);
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   for (genvar g = 0; g < npt_pkg::TABLE_DEPTH; g++) begin : g_cell
      npt_pkg::entry_type above;
      if (g == npt_pkg::TABLE_DEPTH - 1) begin : g_last
         assign above = cells[g];
      end else begin : g_mid
         assign above = cells[g+1];
      end
      npt_cell u_cell (
         .clock    (clock),
         .my_index (npt_pkg::IDX_W'(g)),
         .cmd      (cmd),
         .bcast    (bcast_ff),
         .above    (above),
         .entry    (cells[g]),
         .hit      (hits[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         bcast_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         bcast_ff     <= bcast_in;
      end
      k_ff    <= k_in;
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready)
      else $error("request taken while busy");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (npt_pkg::CNT_W)'(npt_pkg::TABLE_DEPTH))
      else $error("held count past depth");

   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hits))
      else $error("more than one slot closed");

   a_bcast_src: assert property (@(posedge clock) disable iff (reset)
      bcast_ff.valid |-> $past(state_ff == S_FIX))
      else $error("overlap beat outside pass");

endmodule

// ===== sv/npt_cell.sv =====
// npt_cell: one table slot; writes, closes, shifts from its upper neighbor
// and trims its end in the overlap pass. Depends on npt_pkg.

module npt_cell (
   input  logic                          clock,
   input  logic [npt_pkg::IDX_W-1:0]     my_index,
   input  npt_pkg::cmd_type              cmd,
   input  npt_pkg::bcast_type            bcast,
   input  npt_pkg::entry_type            above,
   output npt_pkg::entry_type            entry,
   output logic                          hit
);

   npt_pkg::entry_type entry_ff, entry_in;
   logic               sel;

   assign sel = (my_index == cmd.idx);
   assign hit = (cmd.kind == npt_pkg::CMD_CLOSE) && sel && !entry_ff.closed
                && (entry_ff.note == cmd.entry.note);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (cmd.kind)
         npt_pkg::CMD_WRITE: begin
            if (sel) entry_in = cmd.entry;
         end
         npt_pkg::CMD_CLOSE: begin
            if (hit) begin
               entry_in.end_pos = cmd.entry.end_pos;
               entry_in.closed  = 1'b1;
            end
         end
         npt_pkg::CMD_SHIFT: begin
            if (my_index >= cmd.idx) entry_in = above;
         end
         default: begin
            if (bcast.valid && entry_ff.closed && entry_ff.note == bcast.note
                && bcast.start_pos > entry_ff.start_pos
                && entry_ff.end_pos > bcast.start_pos)
               entry_in.end_pos = bcast.start_pos - 32'sd1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== bench/npt_checker.sv =====
// npt_checker: watches the req_/rsp_ channels of the note pair table,
// predicts each response with its own table model and compares field by field.
// Depends on npt_pkg.

module npt_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  npt_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  npt_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count
);

   npt_pkg::entry_type slots [npt_pkg::TABLE_DEPTH];
   int                 held;
   npt_pkg::rsp_type   expected_rsps [$];

   function automatic npt_pkg::rsp_type apply_req(npt_pkg::req_type r);
      npt_pkg::rsp_type o;
      bit               found;
      o = '0;
      o.status = npt_pkg::ST_OK;
      case (r.opcode)
         npt_pkg::OP_OPEN, npt_pkg::OP_ADD: begin
            if (held >= npt_pkg::TABLE_DEPTH) begin
               o.status = npt_pkg::ST_FULL;
            end else begin
               slots[held].note = r.note_number;
               slots[held].start_pos = r.start_position;
               slots[held].closed = (r.opcode == npt_pkg::OP_ADD) && r.end_present;
               slots[held].end_pos = slots[held].closed ? r.end_position : '0;
               held++;
            end
         end
         npt_pkg::OP_CLOSE: begin
            found = 0;
            for (int k = 0; k < held && !found; k++) begin
               if (!slots[k].closed && slots[k].note == r.note_number) begin
                  slots[k].end_pos = r.end_position;
                  slots[k].closed = 1;
                  found = 1;
               end
            end
            if (!found) o.status = npt_pkg::ST_NO_MATCH;
         end
         npt_pkg::OP_REMOVE: begin
            if (r.entry_index >= held) begin
               o.status = npt_pkg::ST_BAD_INDEX;
            end else begin
               for (int k = r.entry_index; k + 1 < held; k++) slots[k] = slots[k + 1];
               held--;
            end
         end
         npt_pkg::OP_CLEAR: held = 0;
         npt_pkg::OP_FIX: begin
            for (int i = 0; i < held; i++) begin
               if (!slots[i].closed) continue;
               for (int j = 0; j < held; j++) begin
                  if (i == j || slots[i].note != slots[j].note) continue;
                  if (slots[j].start_pos > slots[i].start_pos &&
                      slots[i].end_pos > slots[j].start_pos)
                     slots[i].end_pos = slots[j].start_pos - 1;
               end
            end
         end
         npt_pkg::OP_READ: begin
            if (r.entry_index >= held) begin
               o.status = npt_pkg::ST_BAD_INDEX;
            end else begin
               o.read_note = slots[r.entry_index].note;
               o.read_start = slots[r.entry_index].start_pos;
               o.read_end = slots[r.entry_index].end_pos;
               o.read_end_present = slots[r.entry_index].closed;
            end
         end
         default: ;
      endcase
      o.entry_count = held[6:0];
      return o;
   endfunction

   assign pending_count = expected_rsps.size();

   always @(posedge clock) begin
      npt_pkg::rsp_type want;
      if (reset) begin
         held = 0;
         fail_count = 0;
         expected_rsps.delete();
      end else begin
         if (req_valid && req_ready) expected_rsps = {expected_rsps, apply_req(req_data)};
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response %p", $time, rsp_data);
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (want.status !== rsp_data.status ||
                   want.entry_count !== rsp_data.entry_count ||
                   want.read_note !== rsp_data.read_note ||
                   want.read_start !== rsp_data.read_start ||
                   want.read_end !== rsp_data.read_end ||
                   want.read_end_present !== rsp_data.read_end_present) begin
                  $display("%0t: mismatch expected %p actual %p", $time, want, rsp_data);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

// ===== bench/tb.sv =====
// tb: stimulus and verdict for note_pair_table_top.
// Depends on npt_pkg, note_pair_table_top and npt_checker.

module tb;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             rsp_ready = 0;
   npt_pkg::req_type req_data = '0;
   logic             req_ready, rsp_valid;
   npt_pkg::rsp_type rsp_data;
   int               fail_count, pending_count;
   int               send_idle = 0, recv_idle = 0;
   int               quiet_cycles = 0;

   localparam int WATCHDOG = 20000;

   always #10 clock = ~clock;

   note_pair_table_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   npt_checker i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (!reset) begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   function automatic logic signed [31:0] rand_pos(bit narrow);
      case ($urandom_range(5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $urandom;
         default: return narrow ? $signed($urandom_range(40)) - 20 : $urandom;
      endcase
   endfunction

   // valid stays up between back-to-back beats; dropped only while idling and after the last beat
   task automatic send_beat(npt_pkg::req_type r);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_op(logic [2:0] op, int note, int s, int e, int pres, int idx);
      npt_pkg::req_type r;
      r.opcode = op;
      r.note_number = 7'(note);
      r.start_position = s;
      r.end_position = e;
      r.end_present = 1'(pres);
      r.entry_index = 6'(idx);
      send_beat(r);
   endtask

   task automatic send_random;
      npt_pkg::req_type r;
      int               pick;
      r = $bits(npt_pkg::req_type)'({$urandom, $urandom, $urandom});
      pick = $urandom_range(99);
      r.note_number = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(3));
      r.start_position = rand_pos(1);
      r.end_position = rand_pos(1);
      if (pick < 25) r.opcode = npt_pkg::OP_OPEN;
      else if (pick < 45) r.opcode = npt_pkg::OP_CLOSE;
      else if (pick < 60) r.opcode = npt_pkg::OP_ADD;
      else if (pick < 70) r.opcode = npt_pkg::OP_REMOVE;
      else if (pick < 72) r.opcode = npt_pkg::OP_CLEAR;
      else if (pick < 80) r.opcode = npt_pkg::OP_FIX;
      else if (pick < 98) r.opcode = npt_pkg::OP_READ;
      else r.opcode = npt_pkg::OP_UNUSED;
      if ($urandom_range(2) != 0) r.entry_index = 6'($urandom_range(15));
      send_beat(r);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      // directed: empty table errors, extremes, fill to full, overlap trim
      send_op(npt_pkg::OP_READ, 0, 0, 0, 0, 0);
      send_op(npt_pkg::OP_REMOVE, 0, 0, 0, 0, 63);
      send_op(npt_pkg::OP_CLOSE, 127, 0, 0, 0, 0);
      send_op(npt_pkg::OP_OPEN, 127, 32'sh80000000, 0, 0, 0);
      send_op(npt_pkg::OP_CLOSE, 127, 0, 32'sh7fffffff, 0, 0);
      send_op(npt_pkg::OP_ADD, 127, 100, 500, 1, 0);
      send_op(npt_pkg::OP_ADD, 5, 7, 9, 0, 0);
      send_op(npt_pkg::OP_FIX, 0, 0, 0, 0, 0);
      for (int k = 0; k < 3; k++) send_op(npt_pkg::OP_READ, 0, 0, 0, 0, k);
      send_op(npt_pkg::OP_REMOVE, 0, 0, 0, 0, 0);
      send_op(npt_pkg::OP_READ, 0, 0, 0, 0, 0);
      send_op(npt_pkg::OP_UNUSED, 127, -1, -1, 1, 63);
      for (int k = 0; k < 65; k++) send_op(npt_pkg::OP_OPEN, k, k, 0, 0, 0);
      send_op(npt_pkg::OP_ADD, 1, 1, 1, 1, 0);
      send_op(npt_pkg::OP_READ, 0, 0, 0, 0, 63);
      send_op(npt_pkg::OP_FIX, 0, 0, 0, 0, 0);
      send_op(npt_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 17 : (phase == 1) ? 56 : 0;
         recv_idle = (phase == 0) ? 56 : (phase == 1) ? 17 : 0;
         for (int n = 0; n < 556; n++) send_random();
      end
      req_valid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
sv/npt_pkg.sv
sv/npt_cell.sv
sv/note_pair_table_top.sv
bench/npt_checker.sv
bench/tb.sv
